### hdl/clipped_rect_alpha_blend_fill_macros.svh
// Assertion macros used by the checker file of the rectangle fill block.
`ifndef CLIPPED_RECT_ALPHA_BLEND_FILL_MACROS_SVH
`define CLIPPED_RECT_ALPHA_BLEND_FILL_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CRABF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CRABF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/crabf_pkg.sv
// Package with types, constants and the channel blend function of the rectangle fill block.
`timescale 1ns / 1ps
package crabf_pkg;

  localparam int COORD_BITS = 12;
  localparam int PIX_COORD_W = 12;
  localparam int EDGE_W = 16;
  localparam int SIZE_W = 13;
  localparam int CMP_W = EDGE_W + 1;
  localparam int PIXEL_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MAX_X  = 3'd2,
    REG_MAX_Y  = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_COLOR  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [EDGE_W-1:0] min_x;
    logic signed [EDGE_W-1:0] min_y;
    logic signed [EDGE_W-1:0] max_x;
    logic signed [EDGE_W-1:0] max_y;
    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
    logic [PIXEL_W-1:0]       color;
  } cfg_t;

  localparam logic [SIZE_W-1:0] FRAME_SIZE_RESET = 13'd4096;

  // Rounded (a*s + (255-a)*d) / 255. The quotient by 255 uses the identity
  // floor(w/255) = (w + 1 + (w >> 8)) >> 8, exact for w below 65535.
  function automatic logic [7:0] blend_ch(input logic [7:0] a, input logic [7:0] s,
                                          input logic [7:0] d);
    logic [15:0] p_src;
    logic [15:0] p_dst;
    logic [15:0] v;
    logic [16:0] w;
    logic [16:0] t;
    p_src = 16'(a) * 16'(s);
    p_dst = (16'd255 - 16'(a)) * 16'(d);
    v = p_src + p_dst;
    w = {1'b0, v} + 17'd127;
    t = w + 17'd1 + (w >> 8);
    return t[15:8];
  endfunction

endpackage

### hdl/clipped_rect_alpha_blend_fill.sv
// Top level of the clipped rectangle fill with source-over alpha blend.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i / in_ready_o   pixel_x_i, pixel_y_i, dest_pixel_i
//   out      source     out_valid_o / out_ready_i result_pixel_o, was_written_o
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One pixel is accepted per cycle while the output is not stalled; each pixel
// passes through the input register and then the result register, which lie
// around the window test and the blend logic. A stalled output holds its result
// while the input register still takes one more pixel. Reset clears both valid
// flags and loads the register defaults, frame size 4096.
`timescale 1ns / 1ps
module clipped_rect_alpha_blend_fill (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [crabf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [crabf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [crabf_pkg::PIX_COORD_W-1:0]   pixel_x_i,
  input  logic [crabf_pkg::PIX_COORD_W-1:0]   pixel_y_i,
  input  logic [crabf_pkg::PIXEL_W-1:0]       dest_pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [crabf_pkg::PIXEL_W-1:0]       result_pixel_o,
  output logic                                was_written_o
);
  import crabf_pkg::*;

  cfg_t cfg;

  logic                  s1_valid_q;
  logic                  s1_valid_d;
  logic [COORD_BITS-1:0] s1_x_q;
  logic [COORD_BITS-1:0] s1_y_q;
  logic [PIXEL_W-1:0]    s1_dest_q;
  logic                  out_valid_q;
  logic                  out_valid_d;
  logic [PIXEL_W-1:0]    result_q;
  logic                  written_q;

  logic                  out_free;
  logic                  s1_advance;
  logic                  in_xfer;
  logic                  in_rect;
  logic [PIXEL_W-1:0]    blended;

  crabf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  crabf_window u_window (
    .cfg_i    (cfg),
    .x_i      (s1_x_q),
    .y_i      (s1_y_q),
    .inside_o (in_rect)
  );

  crabf_blend u_blend (
    .color_i   (cfg.color),
    .dest_i    (s1_dest_q),
    .blended_o (blended)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = out_free ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_x_q    <= pixel_x_i[COORD_BITS-1:0];
      s1_y_q    <= pixel_y_i[COORD_BITS-1:0];
      s1_dest_q <= dest_pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      result_q  <= in_rect ? blended : s1_dest_q;
      written_q <= in_rect;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_pixel_o = result_q;
  assign was_written_o  = written_q;

endmodule

### hdl/crabf_regs.sv
// Configuration register file of the rectangle fill block.
`timescale 1ns / 1ps
module crabf_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [crabf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [crabf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output crabf_pkg::cfg_t                    cfg_o
);
  import crabf_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_X:  cfg_d.min_x  = cfg_wdata_i[EDGE_W-1:0];
        REG_MIN_Y:  cfg_d.min_y  = cfg_wdata_i[EDGE_W-1:0];
        REG_MAX_X:  cfg_d.max_x  = cfg_wdata_i[EDGE_W-1:0];
        REG_MAX_Y:  cfg_d.max_y  = cfg_wdata_i[EDGE_W-1:0];
        REG_WIDTH:  cfg_d.width  = cfg_wdata_i[SIZE_W-1:0];
        REG_HEIGHT: cfg_d.height = cfg_wdata_i[SIZE_W-1:0];
        REG_COLOR:  cfg_d.color  = cfg_wdata_i[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x  <= '0;
      cfg_q.min_y  <= '0;
      cfg_q.max_x  <= '0;
      cfg_q.max_y  <= '0;
      cfg_q.width  <= FRAME_SIZE_RESET;
      cfg_q.height <= FRAME_SIZE_RESET;
      cfg_q.color  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/crabf_window.sv
// Clipped rectangle membership test for one pixel coordinate.
`timescale 1ns / 1ps
module crabf_window (
  input  crabf_pkg::cfg_t                   cfg_i,
  input  logic [crabf_pkg::COORD_BITS-1:0]  x_i,
  input  logic [crabf_pkg::COORD_BITS-1:0]  y_i,
  output logic                              inside_o
);
  import crabf_pkg::*;

  logic signed [CMP_W-1:0] min_x_s;
  logic signed [CMP_W-1:0] min_y_s;
  logic signed [CMP_W-1:0] max_x_s;
  logic signed [CMP_W-1:0] max_y_s;
  logic signed [CMP_W-1:0] width_s;
  logic signed [CMP_W-1:0] height_s;
  logic signed [CMP_W-1:0] lo_x;
  logic signed [CMP_W-1:0] lo_y;
  logic signed [CMP_W-1:0] hi_x;
  logic signed [CMP_W-1:0] hi_y;
  logic signed [CMP_W-1:0] x_s;
  logic signed [CMP_W-1:0] y_s;

  always_comb begin
    min_x_s  = CMP_W'(cfg_i.min_x);
    min_y_s  = CMP_W'(cfg_i.min_y);
    max_x_s  = CMP_W'(cfg_i.max_x);
    max_y_s  = CMP_W'(cfg_i.max_y);
    width_s  = signed'({{(CMP_W-SIZE_W){1'b0}}, cfg_i.width});
    height_s = signed'({{(CMP_W-SIZE_W){1'b0}}, cfg_i.height});
    x_s      = signed'({{(CMP_W-COORD_BITS){1'b0}}, x_i});
    y_s      = signed'({{(CMP_W-COORD_BITS){1'b0}}, y_i});

    lo_x = min_x_s[CMP_W-1] ? '0 : min_x_s;
    lo_y = min_y_s[CMP_W-1] ? '0 : min_y_s;
    hi_x = (max_x_s > width_s) ? width_s : max_x_s;
    hi_y = (max_y_s > height_s) ? height_s : max_y_s;

    inside_o = (x_s >= lo_x) && (x_s < hi_x) && (y_s >= lo_y) && (y_s < hi_y);
  end

endmodule

### hdl/crabf_blend.sv
// Source-over blend of the fill color onto one destination pixel.
`timescale 1ns / 1ps
module crabf_blend (
  input  logic [crabf_pkg::PIXEL_W-1:0]  color_i,
  input  logic [crabf_pkg::PIXEL_W-1:0]  dest_i,
  output logic [crabf_pkg::PIXEL_W-1:0]  blended_o
);
  import crabf_pkg::*;

  logic [7:0] alpha;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign alpha = color_i[31:24];
  assign red   = blend_ch(alpha, color_i[23:16], dest_i[23:16]);
  assign green = blend_ch(alpha, color_i[15:8], dest_i[15:8]);
  assign blue  = blend_ch(alpha, color_i[7:0], dest_i[7:0]);

  assign blended_o = {8'h00, red, green, blue};

endmodule

### hdl/crabf_checker.sv
// Port-level checker for the rectangle fill block and its bind to the top level.
`timescale 1ns / 1ps
`include "clipped_rect_alpha_blend_fill_macros.svh"
module crabf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [crabf_pkg::PIXEL_W-1:0]      result_pixel_o,
  input logic                               was_written_o
);
  import crabf_pkg::*;

  `CRABF_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid during reset")
  `CRABF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_pixel_o) && $stable(was_written_o), "stalled result changed")
  `CRABF_ASSERT(a_alpha_zero, out_valid_o && was_written_o |-> result_pixel_o[31:24] == 8'h00, "blended pixel has nonzero alpha")
  `CRABF_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")

endmodule

bind clipped_rect_alpha_blend_fill crabf_checker u_crabf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_pixel_o (result_pixel_o),
  .was_written_o  (was_written_o)
);
